// ===== rtl/brs_pkg.sv =====
// brs_pkg: shared types, constants and helpers for breath_run_statistics
// used by the top level, brs_front and brs_back; depends on nothing

package brs_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int ACC_W        = 40;
    localparam int COUNT_W      = 16;
    localparam int THRESH_W     = 15;
    localparam int MIN_RUN_W    = 16;
    localparam int RUN_LENGTH_W = 16;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_INDEX_W  = 2;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_VOLUME_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_THRESHOLD  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_RUN_LENGTH   = 2'd2;

    localparam logic [THRESH_W-1:0]  VOLUME_THRESHOLD_RESET = 15'd5;
    localparam logic [THRESH_W-1:0]  SPEED_THRESHOLD_RESET  = 15'd10;
    localparam logic [MIN_RUN_W-1:0] MIN_RUN_LENGTH_RESET   = 16'd15;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef struct packed {
        logic                       command;
        logic signed [SAMPLE_W-1:0] sample;
    } brs_item_t;

    typedef struct packed {
        logic signed [ACC_W-1:0]    volume_total;
        logic [COUNT_W-1:0]         breath_total;
        logic signed [SAMPLE_W-1:0] average_volume;
        logic signed [SAMPLE_W-1:0] peak_speed;
        logic signed [SAMPLE_W-1:0] largest_sample;
        logic signed [SAMPLE_W-1:0] smallest_sample;
    } brs_result_t;

    typedef struct packed {
        logic                       command;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       volume_over;
        logic                       speed_over;
    } brs_work_t;

    typedef struct packed {
        logic [THRESH_W-1:0]  volume_threshold;
        logic [THRESH_W-1:0]  speed_threshold;
        logic [MIN_RUN_W-1:0] min_run_length;
    } brs_cfg_t;

    function automatic logic [SAMPLE_W-1:0] magnitude(input logic signed [SAMPLE_W-1:0] v);
        logic [SAMPLE_W-1:0] r;
        r = v[SAMPLE_W-1] ? SAMPLE_W'(~v + 1'b1) : SAMPLE_W'(v);
        return r;
    endfunction

endpackage

// ===== rtl/breath_run_statistics.sv =====
// breath_run_statistics: top level with configuration registers, front and back
// depends on brs_pkg, brs_front, brs_back

// Each request gives exactly one result. The back end takes a request in ST_IDLE and writes
// its result to the output register in ST_OUT. When it closes a qualifying speed run it first
// goes through the 16-step speed division, and when it counts a breath the 40-step average
// division, both on the one shared serial divider. A two-entry request queue keeps push open
// while the back end works and while a finished result waits to be popped.

module breath_run_statistics #(
    parameter int RUN_LENGTH_WIDTH = brs_pkg::RUN_LENGTH_W
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    input  brs_pkg::brs_item_t                 item,
    output logic                               full,
    output logic                               empty,
    input  logic                               pop,
    output brs_pkg::brs_result_t               result,
    input  logic                               write_enable,
    input  logic [brs_pkg::CFG_INDEX_W-1:0]    reg_index,
    input  logic [brs_pkg::CFG_DATA_W-1:0]     write_data
);

    brs_pkg::brs_cfg_t  cfg_reg, cfg_next;
    brs_pkg::brs_work_t work;
    logic               work_valid;
    logic               work_take;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_enable)
        begin
            unique case (reg_index)
                brs_pkg::REG_VOLUME_THRESHOLD:
                    cfg_next.volume_threshold = write_data[brs_pkg::THRESH_W-1:0];
                brs_pkg::REG_SPEED_THRESHOLD:
                    cfg_next.speed_threshold = write_data[brs_pkg::THRESH_W-1:0];
                brs_pkg::REG_MIN_RUN_LENGTH:
                    cfg_next.min_run_length = write_data[brs_pkg::MIN_RUN_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.volume_threshold <= brs_pkg::VOLUME_THRESHOLD_RESET;
            cfg_reg.speed_threshold  <= brs_pkg::SPEED_THRESHOLD_RESET;
            cfg_reg.min_run_length   <= brs_pkg::MIN_RUN_LENGTH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    brs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .item       (item),
        .full       (full),
        .cfg        (cfg_reg),
        .work_valid (work_valid),
        .work       (work),
        .work_take  (work_take)
    );

    brs_back #(
        .RUN_W (RUN_LENGTH_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .min_run_length (cfg_reg.min_run_length),
        .work_valid     (work_valid),
        .work           (work),
        .work_take      (work_take),
        .result         (result),
        .empty          (empty),
        .pop            (pop)
    );

endmodule

// ===== rtl/brs_front.sv =====
// brs_front: takes requests, classifies samples against the thresholds
// and holds them in a short queue for the back end; uses brs_pkg

module brs_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  brs_pkg::brs_item_t  item,
    output logic                full,
    input  brs_pkg::brs_cfg_t   cfg,
    output logic                work_valid,
    output brs_pkg::brs_work_t  work,
    input  logic                work_take
);

    localparam int PTR_W = (brs_pkg::QUEUE_DEPTH > 1) ? $clog2(brs_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(brs_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(brs_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(brs_pkg::QUEUE_DEPTH);

    brs_pkg::brs_work_t queue_reg [brs_pkg::QUEUE_DEPTH];
    brs_pkg::brs_work_t entry;

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [brs_pkg::SAMPLE_W-1:0] mag;
    logic wr_en;
    logic rd_en;

    assign mag = brs_pkg::magnitude(item.sample);

    always_comb
    begin
        entry.command     = item.command;
        entry.sample      = item.sample;
        entry.volume_over = mag > brs_pkg::SAMPLE_W'(cfg.volume_threshold);
        entry.speed_over  = mag > brs_pkg::SAMPLE_W'(cfg.speed_threshold);
    end

    assign full       = (count_reg == FULL_COUNT);
    assign work_valid = (count_reg != '0);
    assign work       = queue_reg[rd_ptr_reg];
    assign wr_en      = push && !full;
    assign rd_en      = work_take && work_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            queue_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

// ===== rtl/brs_div.sv =====
// brs_div: restoring unsigned divider, one quotient bit per cycle
// shared by the speed and average paths of brs_back; no package use

module brs_div #(
    parameter int DIVIDEND_W = 40,
    parameter int DIVISOR_W  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [$clog2(DIVIDEND_W+1)-1:0]     steps,
    input  logic [DIVIDEND_W-1:0]               dividend,
    input  logic [DIVISOR_W-1:0]                divisor,
    output logic                                done,
    output logic [DIVIDEND_W-1:0]               quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  divisor_reg, divisor_next;
    logic [STEP_W-1:0]     left_reg, left_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;

    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign ge    = (trial >= {1'b0, divisor_reg});
    assign diff  = trial - {1'b0, divisor_reg};

    always_comb
    begin
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        left_next    = left_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        if (start)
        begin
            quo_next     = dividend;
            rem_next     = '0;
            divisor_next = divisor;
            left_next    = steps;
            busy_next    = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_next  = {quo_reg[DIVIDEND_W-2:0], ge};
            left_next = left_reg - 1'b1;
            if (left_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            left_reg <= left_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/brs_back.sv =====
// brs_back: run tracking, saturating statistics, speed and average division
// and the result register; uses brs_pkg and brs_div

module brs_back #(
    parameter int RUN_W = brs_pkg::RUN_LENGTH_W
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [brs_pkg::MIN_RUN_W-1:0]     min_run_length,
    input  logic                              work_valid,
    input  brs_pkg::brs_work_t                work,
    output logic                              work_take,
    output brs_pkg::brs_result_t              result,
    output logic                              empty,
    input  logic                              pop
);

    localparam int SW        = brs_pkg::SAMPLE_W;
    localparam int AW        = brs_pkg::ACC_W;
    localparam int CW        = brs_pkg::COUNT_W;
    localparam int CMP_W     = (RUN_W > brs_pkg::MIN_RUN_W) ? RUN_W : brs_pkg::MIN_RUN_W;
    localparam int DIVISOR_W = (RUN_W > CW) ? RUN_W : CW;
    localparam int STEP_W    = $clog2(AW + 1);

    localparam logic [2:0] ST_IDLE       = 3'd0;
    localparam logic [2:0] ST_SPEED      = 3'd1;
    localparam logic [2:0] ST_SPEED_WAIT = 3'd2;
    localparam logic [2:0] ST_AVG        = 3'd3;
    localparam logic [2:0] ST_AVG_WAIT   = 3'd4;
    localparam logic [2:0] ST_OUT        = 3'd5;

    localparam logic signed [AW-1:0] ACC_MAX   = {1'b0, {(AW-1){1'b1}}};
    localparam logic signed [AW-1:0] ACC_MIN   = {1'b1, {(AW-1){1'b0}}};
    localparam logic signed [SW-1:0] SMP_MAX   = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMP_MIN   = {1'b1, {(SW-1){1'b0}}};
    localparam logic [AW-1:0]        POS_LIMIT = AW'({1'b0, {(SW-1){1'b1}}});
    localparam logic [AW-1:0]        NEG_LIMIT = AW'({1'b1, {(SW-1){1'b0}}});
    localparam logic signed [SW-1:0] AVG_EMPTY = SW'(1);

    logic [2:0]               state_reg, state_next;
    logic signed [SW-1:0]     prev_reg, prev_next;
    logic [RUN_W-1:0]         vrun_reg, vrun_next;
    logic [RUN_W-1:0]         srun_reg, srun_next;
    logic signed [AW-1:0]     acc_reg, acc_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic signed [SW-1:0]     peak_reg, peak_next;
    logic signed [SW-1:0]     max_reg, max_next;
    logic signed [SW-1:0]     min_reg, min_next;
    logic                     seen_reg, seen_next;
    logic signed [SW-1:0]     avg_reg, avg_next;
    logic                     need_avg_reg, need_avg_next;
    logic [SW-1:0]            spd_num_reg, spd_num_next;
    logic                     spd_neg_reg, spd_neg_next;
    logic [RUN_W-1:0]         spd_len_reg, spd_len_next;
    logic                     out_valid_reg, out_valid_next;
    brs_pkg::brs_result_t     out_reg, out_next;

    logic [RUN_W-1:0]         vrun_inc;
    logic [RUN_W-1:0]         srun_inc;
    logic                     vrun_done;
    logic                     srun_done;
    logic [AW:0]              acc_sum;
    logic signed [AW-1:0]     acc_sat;
    logic [AW-1:0]            acc_mag;
    logic [SW-1:0]            spd_mag;

    logic                     div_start;
    logic [STEP_W-1:0]        div_steps;
    logic [AW-1:0]            div_dividend;
    logic [DIVISOR_W-1:0]     div_divisor;
    logic                     div_done;
    logic [AW-1:0]            div_quotient;

    brs_div #(
        .DIVIDEND_W (AW),
        .DIVISOR_W  (DIVISOR_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .steps    (div_steps),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign vrun_inc  = (&vrun_reg) ? vrun_reg : vrun_reg + 1'b1;
    assign srun_inc  = (&srun_reg) ? srun_reg : srun_reg + 1'b1;
    assign vrun_done = CMP_W'(vrun_reg) > CMP_W'(min_run_length);
    assign srun_done = CMP_W'(srun_reg) > CMP_W'(min_run_length);
    assign acc_sum   = {acc_reg[AW-1], acc_reg} + (AW+1)'(prev_reg);
    assign acc_sat   = (acc_sum[AW] != acc_sum[AW-1]) ? (acc_sum[AW] ? ACC_MIN : ACC_MAX)
                                                      : acc_sum[AW-1:0];
    assign acc_mag   = acc_reg[AW-1] ? AW'(~acc_reg + 1'b1) : AW'(acc_reg);
    assign spd_mag   = div_quotient[SW-1:0];

    assign work_take = (state_reg == ST_IDLE) && work_valid;

    always_comb
    begin
        state_next     = state_reg;
        prev_next      = prev_reg;
        vrun_next      = vrun_reg;
        srun_next      = srun_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        peak_next      = peak_reg;
        max_next       = max_reg;
        min_next       = min_reg;
        seen_next      = seen_reg;
        avg_next       = avg_reg;
        need_avg_next  = need_avg_reg;
        spd_num_next   = spd_num_reg;
        spd_neg_next   = spd_neg_reg;
        spd_len_next   = spd_len_reg;
        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;
        div_start      = 1'b0;
        div_steps      = STEP_W'(AW);
        div_dividend   = acc_mag;
        div_divisor    = DIVISOR_W'(cnt_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (work_valid)
                begin
                    if (work.command == brs_pkg::CMD_CLEAR)
                    begin
                        prev_next     = '0;
                        vrun_next     = '0;
                        srun_next     = '0;
                        acc_next      = '0;
                        cnt_next      = '0;
                        peak_next     = '0;
                        max_next      = '0;
                        min_next      = '0;
                        seen_next     = 1'b0;
                        avg_next      = AVG_EMPTY;
                        need_avg_next = 1'b0;
                        state_next    = ST_OUT;
                    end
                    else
                    begin
                        need_avg_next = 1'b0;
                        if (work.volume_over)
                        begin
                            vrun_next = vrun_inc;
                        end
                        else
                        begin
                            if (vrun_done)
                            begin
                                acc_next      = acc_sat;
                                cnt_next      = (&cnt_reg) ? cnt_reg : cnt_reg + 1'b1;
                                need_avg_next = 1'b1;
                            end
                            vrun_next = '0;
                        end
                        if (work.speed_over)
                        begin
                            srun_next = srun_inc;
                        end
                        else
                        begin
                            srun_next = '0;
                        end
                        spd_num_next = brs_pkg::magnitude(prev_reg);
                        spd_neg_next = prev_reg[SW-1];
                        spd_len_next = srun_reg;
                        if (!seen_reg)
                        begin
                            max_next  = work.sample;
                            min_next  = work.sample;
                            seen_next = 1'b1;
                        end
                        else
                        begin
                            if (work.sample > max_reg)
                            begin
                                max_next = work.sample;
                            end
                            if (work.sample < min_reg)
                            begin
                                min_next = work.sample;
                            end
                        end
                        prev_next = work.sample;
                        if (!work.speed_over && srun_done)
                        begin
                            state_next = ST_SPEED;
                        end
                        else if (!work.volume_over && vrun_done)
                        begin
                            state_next = ST_AVG;
                        end
                        else
                        begin
                            state_next = ST_OUT;
                        end
                    end
                end
            end
            ST_SPEED:
            begin
                div_start    = 1'b1;
                div_steps    = STEP_W'(SW);
                div_dividend = {spd_num_reg, {(AW-SW){1'b0}}};
                div_divisor  = DIVISOR_W'(spd_len_reg);
                state_next   = ST_SPEED_WAIT;
            end
            ST_SPEED_WAIT:
            begin
                if (div_done)
                begin
                    if (spd_mag > brs_pkg::magnitude(peak_reg))
                    begin
                        peak_next = spd_neg_reg ? SW'(~spd_mag + 1'b1) : SW'(spd_mag);
                    end
                    state_next = need_avg_reg ? ST_AVG : ST_OUT;
                end
            end
            ST_AVG:
            begin
                div_start  = 1'b1;
                state_next = ST_AVG_WAIT;
            end
            ST_AVG_WAIT:
            begin
                if (div_done)
                begin
                    if (acc_reg[AW-1])
                    begin
                        avg_next = (div_quotient > NEG_LIMIT) ? SMP_MIN
                                                              : SW'(~div_quotient + 1'b1);
                    end
                    else
                    begin
                        avg_next = (div_quotient > POS_LIMIT) ? SMP_MAX : SW'(div_quotient);
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_next.volume_total    = acc_reg;
                    out_next.breath_total    = cnt_reg;
                    out_next.average_volume  = avg_reg;
                    out_next.peak_speed      = peak_reg;
                    out_next.largest_sample  = max_reg;
                    out_next.smallest_sample = min_reg;
                    out_valid_next           = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prev_reg      <= '0;
            vrun_reg      <= '0;
            srun_reg      <= '0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            peak_reg      <= '0;
            max_reg       <= '0;
            min_reg       <= '0;
            seen_reg      <= 1'b0;
            avg_reg       <= AVG_EMPTY;
            need_avg_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_reg      <= prev_next;
            vrun_reg      <= vrun_next;
            srun_reg      <= srun_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            peak_reg      <= peak_next;
            max_reg       <= max_next;
            min_reg       <= min_next;
            seen_reg      <= seen_next;
            avg_reg       <= avg_next;
            need_avg_reg  <= need_avg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        spd_num_reg <= spd_num_next;
        spd_neg_reg <= spd_neg_next;
        spd_len_reg <= spd_len_next;
        out_reg     <= out_next;
    end

    assign result = out_reg;
    assign empty  = !out_valid_reg;

    // no breaths counted means the default average between items
    a_avg_default: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && cnt_reg == '0) |-> (avg_reg == AVG_EMPTY))
        else $error("average not at its default with no breaths");

    a_total_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> (acc_reg == '0))
        else $error("volume total nonzero with no breaths");

    a_no_samples: assert property (@(posedge clk) disable iff (!rst_n)
        (!seen_reg) |-> (max_reg == '0 && min_reg == '0 && prev_reg == '0))
        else $error("sample statistics set before any sample");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg |-> (min_reg <= max_reg))
        else $error("smallest sample above largest sample");

endmodule
